@@ rtl/core/rbes_pkg.sv @@
// Package for the rigid body Euler step block: shared types, constants and
// the datapath command structure. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rbes_pkg;

	localparam logic signed [31:0] Q_ONE = 32'sd65536;
	localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S_MIN = 32'sh80000000;

	localparam logic [1:0] REG_GRAVITY = 2'd0;
	localparam logic [1:0] REG_DRAG    = 2'd1;
	localparam logic [1:0] REG_INVMASS = 2'd2;
	localparam logic [1:0] REG_SPIN    = 2'd3;

	// Register file slots of the datapath.
	typedef enum logic [4:0] {
		R_PX, R_PY, R_PZ, R_VX, R_VY, R_VZ, R_WX, R_WY, R_WZ,
		R_AS, R_AX, R_AY, R_AZ,
		R_FX, R_FY, R_FZ, R_TX, R_TY, R_TZ,
		R_H, R_G, R_D, R_M, R_T, R_ZERO, R_T0, R_T1, R_T2
	} reg_sel_t;

	// Operation of the shared unit.
	typedef enum logic [2:0] {
		OP_MUL,      // dst = sat(floor(a*b/2^16))
		OP_ADD,      // dst = sat(a+b)
		OP_SUB,      // dst = sat(a-b)
		OP_ACC_CLR,  // acc = 0
		OP_ACC_ADD,  // acc += floor(a*b/2^16)
		OP_ACC_SUB,  // acc -= floor(a*b/2^16)
		OP_ACC_HALF, // dst = sat(floor(acc/2))
		OP_MAG       // acc += sat(floor(a*b/2^16))
	} op_t;

	typedef struct packed {
		logic     en;
		op_t      op;
		reg_sel_t a;
		reg_sel_t b;
		reg_sel_t dst;
		logic     load;
		logic     pose;
	} dp_cmd_t;

	typedef struct packed {
		logic spin;
	} dp_status_t;

	function automatic logic signed [31:0] sat64(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sh0_7fffffff) r = S_MAX;
		else if (v < -66'sh0_80000000) r = S_MIN;
		else r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/rbes_datapath.sv @@
// Datapath of the rigid body Euler step: state registers, scratch registers
// and one shared multiply/add unit. Depends on rbes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbes_datapath import rbes_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_idx,
	input  wire logic [30:0]        cfg_data,
	input  wire logic [30:0]        in_h,
	input  wire logic signed [31:0] in_a [3],
	input  wire logic signed [31:0] in_b [3],
	input  wire logic signed [31:0] in_s,
	output dp_status_t              status,
	output logic signed [31:0]      rf_out [28]
);

	logic signed [31:0] rf_q [28];
	logic signed [65:0] acc_q;
	logic signed [31:0] opa, opb;
	logic signed [63:0] prod;
	logic signed [47:0] praw;
	logic signed [31:0] res;
	logic               wr;

	assign opa  = rf_q[cmd.a];
	assign opb  = rf_q[cmd.b];
	assign prod = opa * opb;
	assign praw = prod[63:16];

	always_comb begin
		res = '0;
		wr  = 1'b0;
		case (cmd.op)
			OP_MUL: begin
				res = sat64(66'(praw));
				wr  = 1'b1;
			end
			OP_ADD: begin
				res = sat64(66'(opa) + 66'(opb));
				wr  = 1'b1;
			end
			OP_SUB: begin
				res = sat64(66'(opa) - 66'(opb));
				wr  = 1'b1;
			end
			OP_ACC_HALF: begin
				res = sat64(acc_q >>> 1);
				wr  = 1'b1;
			end
			default: ;
		endcase
	end

	assign status.spin = acc_q > 66'(rf_q[R_T]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 28; i++) begin
				if (i == int'(R_AS)) rf_q[i] <= Q_ONE;
				else if (i == int'(R_G)) rf_q[i] <= 32'sd655360;
				else if (i == int'(R_D)) rf_q[i] <= 32'sd6554;
				else if (i == int'(R_M)) rf_q[i] <= 32'sd65536;
				else if (i == int'(R_T)) rf_q[i] <= 32'sd1;
				else rf_q[i] <= '0;
			end
			acc_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_GRAVITY: rf_q[R_G] <= {1'b0, cfg_data};
					REG_DRAG:    rf_q[R_D] <= {1'b0, cfg_data};
					REG_INVMASS: rf_q[R_M] <= {1'b0, cfg_data};
					REG_SPIN:    rf_q[R_T] <= {1'b0, cfg_data};
					default: ;
				endcase
			end
			if (cmd.load) begin
				rf_q[R_H]  <= {1'b0, in_h};
				rf_q[R_FX] <= in_a[0];
				rf_q[R_FY] <= in_a[1];
				rf_q[R_FZ] <= in_a[2];
				rf_q[R_TX] <= in_b[0];
				rf_q[R_TY] <= in_b[1];
				rf_q[R_TZ] <= in_b[2];
				rf_q[R_T0] <= in_s;
			end
			if (cmd.pose) begin
				rf_q[R_PX] <= in_a[0];
				rf_q[R_PY] <= in_a[1];
				rf_q[R_PZ] <= in_a[2];
				rf_q[R_AS] <= in_s;
				rf_q[R_AX] <= in_b[0];
				rf_q[R_AY] <= in_b[1];
				rf_q[R_AZ] <= in_b[2];
			end
			if (cmd.en) begin
				case (cmd.op)
					OP_ACC_CLR: acc_q <= '0;
					OP_ACC_ADD: acc_q <= acc_q + 66'(praw);
					OP_ACC_SUB: acc_q <= acc_q - 66'(praw);
					OP_MAG:     acc_q <= acc_q + 66'(sat64(66'(praw)));
					default: ;
				endcase
				if (wr) rf_q[cmd.dst] <= res;
			end
		end
	end

	assign rf_out = rf_q;

endmodule
`default_nettype wire

@@ rtl/core/rbes_ctrl.sv @@
// Sequencer of the rigid body Euler step: walks the microprogram for a tick,
// handles a pose load and drives the datapath commands. Depends on rbes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbes_ctrl import rbes_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       in_cmd,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd,
	output logic            done
);

	typedef enum logic [1:0] {ST_IDLE, ST_TICK, ST_POSE} state_t;

	localparam int unsigned NSTEP = 61;

	state_t     state_q;
	logic [5:0] pc_q;
	dp_cmd_t    uop;

	function automatic dp_cmd_t mk(input op_t o, input reg_sel_t a, input reg_sel_t b,
			input reg_sel_t d);
		dp_cmd_t c;
		c.en = 1'b1; c.op = o; c.a = a; c.b = b; c.dst = d; c.load = 1'b0; c.pose = 1'b0;
		return c;
	endfunction

	always_comb begin
		uop = mk(OP_ACC_CLR, R_ZERO, R_ZERO, R_ZERO);
		case (pc_q)
			6'd0:  uop = mk(OP_SUB, R_FY, R_G, R_FY);
			6'd1:  uop = mk(OP_MUL, R_VX, R_D, R_T1);
			6'd2:  uop = mk(OP_SUB, R_FX, R_T1, R_FX);
			6'd3:  uop = mk(OP_MUL, R_VY, R_D, R_T1);
			6'd4:  uop = mk(OP_SUB, R_FY, R_T1, R_FY);
			6'd5:  uop = mk(OP_MUL, R_VZ, R_D, R_T1);
			6'd6:  uop = mk(OP_SUB, R_FZ, R_T1, R_FZ);
			6'd7:  uop = mk(OP_MUL, R_WX, R_D, R_T1);
			6'd8:  uop = mk(OP_SUB, R_TX, R_T1, R_TX);
			6'd9:  uop = mk(OP_MUL, R_WY, R_D, R_T1);
			6'd10: uop = mk(OP_SUB, R_TY, R_T1, R_TY);
			6'd11: uop = mk(OP_MUL, R_WZ, R_D, R_T1);
			6'd12: uop = mk(OP_SUB, R_TZ, R_T1, R_TZ);
			6'd13: uop = mk(OP_MUL, R_VX, R_H, R_T1);
			6'd14: uop = mk(OP_ADD, R_PX, R_T1, R_PX);
			6'd15: uop = mk(OP_MUL, R_VY, R_H, R_T1);
			6'd16: uop = mk(OP_ADD, R_PY, R_T1, R_PY);
			6'd17: uop = mk(OP_MUL, R_VZ, R_H, R_T1);
			6'd18: uop = mk(OP_ADD, R_PZ, R_T1, R_PZ);
			6'd19: uop = mk(OP_MUL, R_FX, R_M, R_FX);
			6'd20: uop = mk(OP_MUL, R_FY, R_M, R_FY);
			6'd21: uop = mk(OP_MUL, R_FZ, R_M, R_FZ);
			6'd22: uop = mk(OP_MUL, R_TX, R_M, R_TX);
			6'd23: uop = mk(OP_MUL, R_TY, R_M, R_TY);
			6'd24: uop = mk(OP_MUL, R_TZ, R_M, R_TZ);
			6'd25: uop = mk(OP_MUL, R_FX, R_H, R_FX);
			6'd26: uop = mk(OP_MUL, R_FY, R_H, R_FY);
			6'd27: uop = mk(OP_MUL, R_FZ, R_H, R_FZ);
			6'd28: uop = mk(OP_MUL, R_TX, R_H, R_TX);
			6'd29: uop = mk(OP_MUL, R_TY, R_H, R_TY);
			6'd30: uop = mk(OP_MUL, R_TZ, R_H, R_TZ);
			6'd31: uop = mk(OP_ADD, R_VX, R_FX, R_VX);
			6'd32: uop = mk(OP_ADD, R_VY, R_FY, R_VY);
			6'd33: uop = mk(OP_ADD, R_VZ, R_FZ, R_VZ);
			6'd34: uop = mk(OP_ADD, R_WX, R_TX, R_WX);
			6'd35: uop = mk(OP_ADD, R_WY, R_TY, R_WY);
			6'd36: uop = mk(OP_ADD, R_WZ, R_TZ, R_WZ);
			6'd37: uop = mk(OP_ACC_CLR, R_ZERO, R_ZERO, R_ZERO);
			6'd38: uop = mk(OP_MAG, R_WX, R_WX, R_ZERO);
			6'd39: uop = mk(OP_MAG, R_WY, R_WY, R_ZERO);
			6'd40: uop = mk(OP_MAG, R_WZ, R_WZ, R_ZERO);
			// Scalar term into T0, x into T1, y into T2, z into FX.
			6'd41: uop = mk(OP_ACC_CLR, R_ZERO, R_ZERO, R_ZERO);
			6'd42: uop = mk(OP_ACC_SUB, R_WX, R_AX, R_ZERO);
			6'd43: uop = mk(OP_ACC_SUB, R_WY, R_AY, R_ZERO);
			6'd44: uop = mk(OP_ACC_SUB, R_WZ, R_AZ, R_ZERO);
			6'd45: uop = mk(OP_ACC_HALF, R_ZERO, R_ZERO, R_T0);
			6'd46: uop = mk(OP_ACC_CLR, R_ZERO, R_ZERO, R_ZERO);
			6'd47: uop = mk(OP_ACC_ADD, R_AS, R_WX, R_ZERO);
			6'd48: uop = mk(OP_ACC_ADD, R_WY, R_AZ, R_ZERO);
			6'd49: uop = mk(OP_ACC_SUB, R_WZ, R_AY, R_ZERO);
			6'd50: uop = mk(OP_ACC_HALF, R_ZERO, R_ZERO, R_T1);
			6'd51: uop = mk(OP_ACC_CLR, R_ZERO, R_ZERO, R_ZERO);
			6'd52: uop = mk(OP_ACC_ADD, R_AS, R_WY, R_ZERO);
			6'd53: uop = mk(OP_ACC_ADD, R_WZ, R_AX, R_ZERO);
			6'd54: uop = mk(OP_ACC_SUB, R_WX, R_AZ, R_ZERO);
			6'd55: uop = mk(OP_ACC_HALF, R_ZERO, R_ZERO, R_T2);
			6'd56: uop = mk(OP_ACC_CLR, R_ZERO, R_ZERO, R_ZERO);
			6'd57: uop = mk(OP_ACC_ADD, R_AS, R_WZ, R_ZERO);
			6'd58: uop = mk(OP_ACC_ADD, R_WX, R_AY, R_ZERO);
			6'd59: uop = mk(OP_ACC_SUB, R_WY, R_AX, R_ZERO);
			6'd60: uop = mk(OP_ACC_HALF, R_ZERO, R_ZERO, R_FX);
			default: ;
		endcase
	end

	// Tail of the tick: scale three of the four attitude gains by the step.
	dp_cmd_t tail;
	always_comb begin
		tail = mk(OP_ACC_CLR, R_ZERO, R_ZERO, R_ZERO);
		case (pc_q)
			6'd61: tail = mk(OP_MUL, R_T0, R_H, R_T0);
			6'd62: tail = mk(OP_MUL, R_T1, R_H, R_T1);
			6'd63: tail = mk(OP_MUL, R_T2, R_H, R_T2);
			default: ;
		endcase
	end

	logic [2:0] fin_q;

	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		if (state_q == ST_IDLE) begin
			cmd.load = in_valid;
			cmd.pose = in_valid & in_cmd;
		end else if (state_q == ST_TICK) begin
			if (pc_q < 6'(NSTEP)) cmd = uop;
			else if (fin_q == 3'd0) cmd = tail;
			else begin
				unique case (fin_q)
					3'd1: cmd = mk(OP_MUL, R_FX, R_H, R_FX);
					3'd2: cmd = mk(OP_ADD, R_AS, R_T0, R_AS);
					3'd3: cmd = mk(OP_ADD, R_AX, R_T1, R_AX);
					3'd4: cmd = mk(OP_ADD, R_AY, R_T2, R_AY);
					3'd5: cmd = mk(OP_ADD, R_AZ, R_FX, R_AZ);
					default: cmd = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			fin_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					pc_q  <= '0;
					fin_q <= '0;
					if (in_valid) state_q <= in_cmd ? ST_POSE : ST_TICK;
				end
				ST_POSE: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
				end
				ST_TICK: begin
					if (pc_q == 6'd41 && !status.spin) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
					end else if (pc_q < 6'd63) begin
						pc_q <= pc_q + 6'd1;
					end else if (fin_q < 3'd5) begin
						fin_q <= fin_q + 3'd1;
					end else begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/rigid_body_euler_step_top.sv @@
// Top level of the rigid body Euler step: sequencer, datapath and output
// register. Depends on rbes_pkg, rbes_ctrl and rbes_datapath.
//
// An input item is taken when in_valid is high and in_stall low. A pose load
// (command one) sets position and attitude. A tick runs a microprogram on
// one shared 32x32 multiply/add unit; it ends early when the squared angular
// rate stays at or below spin_threshold, and integrates the attitude as well
// otherwise. One item is in work at a time.
// Each item gives one result item on out_valid, held until taken with
// out_stall low. A new input item is held off until the previous result has
// been taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) must come while the
// block is idle. Reset sets position, velocity and rate to zero, attitude to
// the identity and the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module rigid_body_euler_step_top import rbes_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic [30:0]        time_step,
	input  wire logic signed [31:0] a_x,
	input  wire logic signed [31:0] a_y,
	input  wire logic signed [31:0] a_z,
	input  wire logic signed [31:0] b_x,
	input  wire logic signed [31:0] b_y,
	input  wire logic signed [31:0] b_z,
	input  wire logic signed [31:0] b_s,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y,
	output logic signed [31:0]      vel_z,
	output logic signed [31:0]      att_s,
	output logic signed [31:0]      att_x,
	output logic signed [31:0]      att_y,
	output logic signed [31:0]      att_z,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [30:0]        cfg_data
);

	dp_cmd_t            cmd;
	dp_status_t         status;
	logic               done, ctrl_stall, pend_q, gate;
	logic signed [31:0] rf [28];
	logic signed [31:0] in_a [3];
	logic signed [31:0] in_b [3];

	assign in_a = '{a_x, a_y, a_z};
	assign in_b = '{b_x, b_y, b_z};

	// Hold new items from the take of an item until its result has left the output register.
	assign gate     = pend_q;
	assign in_stall = ctrl_stall | gate;

	rbes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid & ~gate), .in_stall(ctrl_stall), .in_cmd(command),
		.status(status), .cmd(cmd), .done(done)
	);

	rbes_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.in_h(time_step), .in_a(in_a), .in_b(in_b), .in_s(b_s),
		.status(status), .rf_out(rf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (in_valid && !in_stall) pend_q <= 1'b1;
			if (done) begin
				out_valid <= 1'b1;
			end
			if (out_valid && !out_stall && !done) pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			pos_x <= rf[R_PX]; pos_y <= rf[R_PY]; pos_z <= rf[R_PZ];
			vel_x <= rf[R_VX]; vel_y <= rf[R_VY]; vel_z <= rf[R_VZ];
			att_s <= rf[R_AS]; att_x <= rf[R_AX]; att_y <= rf[R_AY]; att_z <= rf[R_AZ];
		end
	end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for rigid_body_euler_step_top: random and directed
// tick and pose-load items checked field by field against a built-in predictor.
// Depends on rbes_pkg and the RTL of the block.
`timescale 1ns / 1ps
module testbench;
	import rbes_pkg::*;

	typedef struct {
		logic               command;
		logic [30:0]        time_step;
		logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, b_s;
	} body_item_t;

	typedef struct {
		logic signed [31:0] f [10];
	} body_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	logic [30:0] time_step = '0;
	logic signed [31:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0, b_s = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, att_s, att_x, att_y, att_z;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;

	body_item_t pending_items [$];
	body_state_t expected_states [$];
	int mismatch_count = 0;
	bit idle_enabled = 1'b1;
	bit drive_enabled = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	logic signed [31:0] gravity_w, drag_k, inv_mass, spin_thr;
	logic signed [31:0] pos [3];
	logic signed [31:0] vel [3];
	logic signed [31:0] rate [3];
	logic signed [31:0] att [4];

	rigid_body_euler_step_top DUT (.*);

	always #6 clk = ~clk;

	function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
		if (v > 66'sh0_7fffffff) return 32'sh7fffffff;
		if (v < -66'sh0_80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [65:0] qprod_raw(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b);
		return p >>> 16;
	endfunction

	function automatic logic signed [31:0] qprod(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clamp32(qprod_raw(a, b));
	endfunction

	function automatic logic signed [31:0] qsum(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clamp32(66'(a) + 66'(b));
	endfunction

	function automatic logic signed [31:0] qdiff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clamp32(66'(a) - 66'(b));
	endfunction

	task automatic reset_body();
		gravity_w = 32'sd655360;
		drag_k = 32'sd6554;
		inv_mass = 32'sd65536;
		spin_thr = 32'sd1;
		for (int i = 0; i < 3; i++) begin
			pos[i] = '0;
			vel[i] = '0;
			rate[i] = '0;
		end
		att[0] = Q_ONE;
		att[1] = '0;
		att[2] = '0;
		att[3] = '0;
	endtask

	function automatic logic signed [31:0] attitude_gain(input logic signed [65:0] acc,
			input logic signed [31:0] h);
		return qprod(clamp32(acc >>> 1), h);
	endfunction

	task automatic advance_body(input body_item_t it);
		logic signed [31:0] h, force_v [3], torque_v [3], w [3], q [4];
		logic signed [65:0] mag, acc;
		body_state_t st;
		h = {1'b0, it.time_step};
		if (it.command) begin
			pos[0] = it.a_x;
			pos[1] = it.a_y;
			pos[2] = it.a_z;
			att[0] = it.b_s;
			att[1] = it.b_x;
			att[2] = it.b_y;
			att[3] = it.b_z;
		end else begin
			force_v[0] = it.a_x;
			force_v[1] = qdiff(it.a_y, gravity_w);
			force_v[2] = it.a_z;
			torque_v[0] = it.b_x;
			torque_v[1] = it.b_y;
			torque_v[2] = it.b_z;
			for (int i = 0; i < 3; i++) begin
				force_v[i] = qdiff(force_v[i], qprod(vel[i], drag_k));
				torque_v[i] = qdiff(torque_v[i], qprod(rate[i], drag_k));
				pos[i] = qsum(pos[i], qprod(vel[i], h));
			end
			for (int i = 0; i < 3; i++) begin
				vel[i] = qsum(vel[i], qprod(qprod(force_v[i], inv_mass), h));
				rate[i] = qsum(rate[i], qprod(qprod(torque_v[i], inv_mass), h));
			end
			mag = 0;
			for (int i = 0; i < 3; i++)
				mag += 66'(qprod(rate[i], rate[i]));
			if (mag > 66'(spin_thr)) begin
				w = rate;
				q = att;
				acc = -(qprod_raw(w[0], q[1]) + qprod_raw(w[1], q[2]) + qprod_raw(w[2], q[3]));
				att[0] = qsum(q[0], attitude_gain(acc, h));
				acc = qprod_raw(q[0], w[0]) + qprod_raw(w[1], q[3]) - qprod_raw(w[2], q[2]);
				att[1] = qsum(q[1], attitude_gain(acc, h));
				acc = qprod_raw(q[0], w[1]) + qprod_raw(w[2], q[1]) - qprod_raw(w[0], q[3]);
				att[2] = qsum(q[2], attitude_gain(acc, h));
				acc = qprod_raw(q[0], w[2]) + qprod_raw(w[0], q[2]) - qprod_raw(w[1], q[1]);
				att[3] = qsum(q[3], attitude_gain(acc, h));
			end
		end
		for (int i = 0; i < 3; i++) begin
			st.f[i] = pos[i];
			st.f[3 + i] = vel[i];
		end
		for (int i = 0; i < 4; i++)
			st.f[6 + i] = att[i];
		expected_states.push_back(st);
	endtask

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatch_count++;
	endtask

	// Sender: takes items from the pending queue, with random idle bursts.
	always @(posedge clk) begin
		body_item_t it;
		if (in_valid && !in_stall) begin
			advance_body(pending_items.pop_front());
		end
		if (!(in_valid && in_stall)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (drive_enabled && pending_items.size() > 0
					&& !(in_valid && !in_stall && pending_items.size() == 0)) begin
				if (idle_enabled && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 18);
					in_valid <= 1'b0;
				end else begin
					it = pending_items[0];
					in_valid <= 1'b1;
					command <= it.command;
					time_step <= it.time_step;
					a_x <= it.a_x;
					a_y <= it.a_y;
					a_z <= it.a_z;
					b_x <= it.b_x;
					b_y <= it.b_y;
					b_z <= it.b_z;
					b_s <= it.b_s;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts and comparison with the predicted state.
	always @(posedge clk) begin
		body_state_t st;
		logic signed [31:0] got [10];
		if (out_valid && !out_stall) begin
			got = '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, att_s, att_x, att_y, att_z};
			if (expected_states.size() == 0) begin
				report_mismatch("unexpected item", got[0], 0);
			end else begin
				st = expected_states.pop_front();
				for (int i = 0; i < 10; i++)
					if (got[i] !== st.f[i])
						report_mismatch($sformatf("field %0d", i), got[i], st.f[i]);
			end
		end
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_stall <= 1'b1;
		end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
			recv_gap <= $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_register(input logic [1:0] idx, input logic [30:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GRAVITY: gravity_w = {1'b0, value};
			REG_DRAG:    drag_k = {1'b0, value};
			REG_INVMASS: inv_mass = {1'b0, value};
			REG_SPIN:    spin_thr = {1'b0, value};
		endcase
	endtask

	task automatic drain();
		drive_enabled = 1'b1;
		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_states.size() == 0);
		drive_enabled = 1'b0;
		repeat (80) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
			3: return $signed($urandom_range(0, 1 << 14)) - (1 << 13);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_item(input logic cmd, input logic [30:0] h,
			input logic signed [31:0] ax, ay, az, bx, by, bz, bs);
		body_item_t it;
		it.command = cmd;
		it.time_step = h;
		it.a_x = ax;
		it.a_y = ay;
		it.a_z = az;
		it.b_x = bx;
		it.b_y = by;
		it.b_z = bz;
		it.b_s = bs;
		pending_items.push_back(it);
	endtask

	task automatic queue_random(input int count);
		logic [30:0] h;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: h = 31'($urandom);
				1: h = 31'($urandom_range(0, 1 << 16));
				default: h = 31'($urandom_range(0, 1 << 12));
			endcase
			queue_item($urandom_range(0, 7) == 0, h, rand_value(), rand_value(), rand_value(),
				rand_value(), rand_value(), rand_value(), rand_value());
		end
	endtask

	initial begin
		reset_body();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: defaults, extremes, pose loads, spin on and off.
		queue_item(1'b0, 31'd65536, '0, '0, '0, '0, '0, '0, '0);
		queue_item(1'b0, 31'h7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		queue_item(1'b0, 31'h7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		queue_item(1'b1, 31'h7fffffff, 32'sh7fffffff, 32'sh80000000, 0,
			32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff);
		queue_item(1'b1, 31'd0, 0, 0, 0, 0, 0, 0, Q_ONE);
		queue_item(1'b0, 31'd6554, 0, 0, 0, 32'sd65536, 32'sd131072, -32'sd65536, 0);
		queue_item(1'b0, 31'd0, 32'sd1000, 0, 0, 0, 0, 0, 0);
		queue_item(1'b0, 31'd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
		drain();
		// Zero inverse mass (forces have no effect), no drag, no gravity, high spin threshold.
		write_register(REG_INVMASS, 31'd0);
		write_register(REG_DRAG, 31'd0);
		write_register(REG_GRAVITY, 31'd0);
		write_register(REG_SPIN, 31'h7fffffff);
		queue_item(1'b0, 31'd65536, 32'sh7fffffff, 0, 0, 32'sh7fffffff, 0, 0, 0);
		queue_random(10);
		// Sender holds back here until every result has come.
		drain();
		write_register(REG_INVMASS, 31'h7fffffff);
		write_register(REG_DRAG, 31'h7fffffff);
		write_register(REG_GRAVITY, 31'h7fffffff);
		write_register(REG_SPIN, 31'd0);
		queue_random(40);
		drain();
		write_register(REG_INVMASS, 31'd65536);
		write_register(REG_DRAG, 31'd6554);
		write_register(REG_GRAVITY, 31'd655360);
		write_register(REG_SPIN, 31'd1);
		queue_random(200);
		drain();
		write_register(REG_INVMASS, 31'd32768);
		write_register(REG_DRAG, 31'd1000);
		write_register(REG_SPIN, 31'd65536);
		queue_random(250);
		drain();
		idle_enabled = 1'b0;
		queue_random(100);
		drain();
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
